FILE: hw/rtl/ptr_pkg.sv
package ptr_pkg;

   localparam int CELLS      = 4096;
   localparam int FRAC_BITS  = 16;
   localparam int CELL_W     = 12;
   localparam int SAMPLE_W   = 32;
   localparam int VALUE_W    = 64;
   localparam int MEAN_W     = 48;
   localparam int CNT_W      = 16;
   localparam int MODE_W     = 3;
   localparam int CMD_W      = 2;
   localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int REC_W      = VALUE_W + MEAN_W + CNT_W + 1;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;
   localparam logic [MODE_W-1:0] MODE_RESET = 3'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_FINAL = 2'd2
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_MIN  = 3'd0,
      MODE_MAX  = 3'd1,
      MODE_MEAN = 3'd2,
      MODE_SUM  = 3'd3,
      MODE_CNT  = 3'd4,
      MODE_PROD = 3'd5,
      MODE_VAR  = 3'd6,
      MODE_SD   = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CLEAR,
      S_ACC,
      S_MUL_PROD,
      S_DIV_MEAN,
      S_MUL_DEV,
      S_WRITE,
      S_FIN,
      S_DIV_FIN,
      S_SQRT,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_LOAD,
      OP_CLEAR,
      OP_SIMPLE,
      OP_MUL_P,
      OP_PROD_END,
      OP_DIV_D,
      OP_MEAN,
      OP_WEL_END,
      OP_WRITE,
      OP_DIV_N,
      OP_DIV_N1,
      OP_SQRT,
      OP_RES_PLAIN,
      OP_RES_DIV
   } op_type;

   typedef struct packed {
      op_type op;
      logic   res_sqrt;
      logic   emit;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      mode_type mode;
      logic     cell_ok;
      logic     sample_valid;
      logic     cnt_zero;
      logic     cnt_le1;
      logic     unit_busy;
      logic     rsp_busy;
   } dp_sts_type;

endpackage

FILE: hw/rtl/per_cell_temporal_reducer.sv
// Channel   Dir  Fields (low bit up)
// req_      in   tdata: cell_req[11:0], sample[43:12]; tuser: cmd[1:0], sample_valid[2]
// rsp_      out  tdata: result_cell[11:0], value[75:12]; tuser: value_valid[0], saturated[1]
// csr_      in   wdata: mode[2:0]
//
// One word at a time. Clear is a single store write; accumulate in min/max/mean/sum/count
// is a single record update, product runs the multiplier (four 32x32 partial products),
// variance/sd run the 64-step divider for the mean, then the multiplier. Finalize runs the
// divider for the mean/variance divide and then the square root for sd.
// Cell store is one RAM, registered read; not cleared at reset.
// A finalize holds in its last cycle while the previous result is still waiting.
module per_cell_temporal_reducer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptr_pkg::REQ_DATA_W-1:0]     req_tdata,  // cell_req, sample
   input  logic [ptr_pkg::REQ_USER_W-1:0]     req_tuser,  // cmd, sample_valid
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // result_cell, value
   output logic [ptr_pkg::RSP_USER_W-1:0]     rsp_tuser,  // value_valid, saturated
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptr_pkg::MODE_W-1:0]         csr_wdata
);

   ptr_pkg::dp_cmd_type dp_cmd;
   ptr_pkg::dp_sts_type dp_sts;

   assign csr_ready = 1'b1;

   ptr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

   ptr_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

`ifndef SYNTH
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[75:12] == 64'd0)
      else $error("invalid result with nonzero value");

   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == ptr_pkg::OP_WRITE || dp_cmd.op == ptr_pkg::OP_CLEAR) |-> !req_tready)
      else $error("store write while accepting");
`endif

endmodule

FILE: hw/rtl/ptr_ram.sv
module ptr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hw/rtl/ptr_datapath.sv
module ptr_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ptr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [ptr_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                               csr_valid,
   input  logic [ptr_pkg::MODE_W-1:0]         csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ptr_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  ptr_pkg::dp_cmd_type                dp_cmd,
   output ptr_pkg::dp_sts_type                dp_sts
);

   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< ptr_pkg::FRAC_BITS;

   function automatic logic [64:0] add_sat(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = 65'(a) + 65'(b);
      if (sum[64] != sum[63]) begin
         return sum[64] ? {1'b1, MIN64} : {1'b1, MAX64};
      end
      return {1'b0, sum[63:0]};
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // latched request
   ptr_pkg::cmd_type              cmd_ff;
   logic [ptr_pkg::CELL_W-1:0]    cell_ff;
   logic signed [31:0]            sample_ff;
   logic                          svalid_ff;
   ptr_pkg::mode_type             mode_ff;

   // cell record
   logic signed [63:0]            acc_ff;
   logic [ptr_pkg::MEAN_W-1:0]    mean_ff;
   logic [ptr_pkg::CNT_W-1:0]     cnt_ff;
   logic                          mark_ff;

   // multiplier
   logic [63:0]  ma_ff, mb_ff, pp_ff;
   logic [1:0]   psh_ff;
   logic [127:0] prod_ff;
   logic [2:0]   mstep_ff;
   logic         mneg_ff, mbusy_ff;

   // divider
   logic [63:0]  dvd_ff;
   logic [15:0]  dvs_ff, drem_ff;
   logic [5:0]   dcnt_ff;
   logic         dneg_ff, dbusy_ff;

   // square root
   logic [127:0] rad_ff;
   logic [63:0]  root_ff;
   logic [65:0]  srem_ff;
   logic [5:0]   scnt_ff;
   logic         sbusy_ff;

   // result and output
   logic signed [63:0]          res_val_ff;
   logic                        res_ok_ff;
   logic                        rsp_valid_ff;
   logic [ptr_pkg::CELL_W-1:0]  rsp_cell_ff;
   logic [63:0]                 rsp_value_ff;
   logic                        rsp_ok_ff, rsp_sat_ff;

   logic [ptr_pkg::REC_W-1:0]   ram_rdata, ram_wdata;
   logic                        ram_we;

   logic signed [63:0] s64, m64, d64, q64, mn64, e64, mulq, clear_acc;
   logic               mulsat, cnt_full, cnt_lost;
   logic [ptr_pkg::CNT_W-1:0] n_new;
   logic [127:0] prod_sh, pp_ext;
   logic [31:0]  a_part, b_part;
   logic [16:0]  drem_sh;
   logic [67:0]  srem_sh, strial;

   assign s64  = 64'(sample_ff);
   assign m64  = 64'(signed'(mean_ff));
   assign d64  = s64 - m64;
   assign q64  = dneg_ff ? 64'(-signed'(dvd_ff)) : signed'(dvd_ff);
   assign mn64 = m64 + q64;
   assign e64  = d64 - q64;
   assign clear_acc = (mode_ff == ptr_pkg::MODE_PROD) ? ONE_Q : 64'sd0;

   assign cnt_full = &cnt_ff;
   assign n_new    = cnt_full ? cnt_ff : cnt_ff + 1'b1;
   assign cnt_lost = cnt_full && (mode_ff inside {ptr_pkg::MODE_MEAN, ptr_pkg::MODE_VAR,
                                                  ptr_pkg::MODE_SD});

   // Q product of magnitudes, signed and clamped
   always_comb begin
      prod_sh = prod_ff >> ptr_pkg::FRAC_BITS;
      mulsat  = 1'b0;
      if (mneg_ff) begin
         if ((|prod_sh[127:64]) || (prod_sh[63:0] > 64'h8000_0000_0000_0000)) begin
            mulsat = 1'b1;
            mulq   = MIN64;
         end else begin
            mulq = 64'(-signed'(prod_sh[63:0]));
         end
      end else begin
         if ((|prod_sh[127:64]) || prod_sh[63]) begin
            mulsat = 1'b1;
            mulq   = MAX64;
         end else begin
            mulq = signed'(prod_sh[63:0]);
         end
      end
   end

   always_comb begin
      a_part = mstep_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_part = mstep_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      case (psh_ff)
         2'd0:    pp_ext = {64'd0, pp_ff};
         2'd1:    pp_ext = {32'd0, pp_ff, 32'd0};
         default: pp_ext = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (dp_cmd.op == ptr_pkg::OP_MUL_P || dp_cmd.op == ptr_pkg::OP_MEAN) begin
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff && mstep_ff == 3'd4) begin
         mbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == ptr_pkg::OP_MUL_P) begin
         ma_ff    <= mag(acc_ff);
         mb_ff    <= mag(s64);
         mneg_ff  <= acc_ff[63] ^ s64[63];
         prod_ff  <= '0;
         mstep_ff <= '0;
      end else if (dp_cmd.op == ptr_pkg::OP_MEAN) begin
         ma_ff    <= mag(d64);
         mb_ff    <= mag(e64);
         mneg_ff  <= d64[63] ^ e64[63];
         prod_ff  <= '0;
         mstep_ff <= '0;
      end else if (mbusy_ff) begin
         if (mstep_ff != 3'd4) begin
            pp_ff  <= 64'(a_part) * 64'(b_part);
            psh_ff <= 2'({1'b0, mstep_ff[1]} + {1'b0, mstep_ff[0]});
         end
         if (mstep_ff != 3'd0) begin
            prod_ff <= prod_ff + pp_ext;
         end
         mstep_ff <= mstep_ff + 1'b1;
      end
   end

   // restoring divider, one quotient bit a cycle
   assign drem_sh = {drem_ff, dvd_ff[63]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (dp_cmd.op == ptr_pkg::OP_DIV_D || dp_cmd.op == ptr_pkg::OP_DIV_N ||
                   dp_cmd.op == ptr_pkg::OP_DIV_N1) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dcnt_ff == 6'd63) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (dp_cmd.op)
         ptr_pkg::OP_DIV_D: begin
            dvd_ff  <= mag(d64);
            dneg_ff <= d64[63];
            dvs_ff  <= n_new;
            drem_ff <= '0;
            dcnt_ff <= '0;
         end
         ptr_pkg::OP_DIV_N, ptr_pkg::OP_DIV_N1: begin
            dvd_ff  <= mag(acc_ff);
            dneg_ff <= acc_ff[63];
            dvs_ff  <= (dp_cmd.op == ptr_pkg::OP_DIV_N) ? cnt_ff : cnt_ff - 1'b1;
            drem_ff <= '0;
            dcnt_ff <= '0;
         end
         default: begin
            if (dbusy_ff) begin
               if (drem_sh >= {1'b0, dvs_ff}) begin
                  drem_ff <= 16'(drem_sh - {1'b0, dvs_ff});
                  dvd_ff  <= {dvd_ff[62:0], 1'b1};
               end else begin
                  drem_ff <= drem_sh[15:0];
                  dvd_ff  <= {dvd_ff[62:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
            end
         end
      endcase
   end

   // digit-by-digit root, two radicand bits a cycle
   assign srem_sh = {srem_ff, rad_ff[127:126]};
   assign strial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (dp_cmd.op == ptr_pkg::OP_SQRT) begin
         sbusy_ff <= 1'b1;
      end else if (sbusy_ff && scnt_ff == 6'd63) begin
         sbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == ptr_pkg::OP_SQRT) begin
         rad_ff  <= (!q64[63] && q64 != 64'sd0) ?
                    ({64'd0, 64'(q64)} << ptr_pkg::FRAC_BITS) : '0;
         root_ff <= '0;
         srem_ff <= '0;
         scnt_ff <= '0;
      end else if (sbusy_ff) begin
         if (srem_sh >= strial) begin
            srem_ff <= 66'(srem_sh - strial);
            root_ff <= {root_ff[62:0], 1'b1};
         end else begin
            srem_ff <= srem_sh[65:0];
            root_ff <= {root_ff[62:0], 1'b0};
         end
         rad_ff  <= rad_ff << 2;
         scnt_ff <= scnt_ff + 1'b1;
      end
   end

   // request latch and mode
   always_ff @(posedge clock) begin
      if (dp_cmd.op == ptr_pkg::OP_LATCH) begin
         cmd_ff    <= ptr_pkg::cmd_type'(req_tuser[1:0]);
         svalid_ff <= req_tuser[2];
         cell_ff   <= req_tdata[ptr_pkg::CELL_W-1:0];
         sample_ff <= signed'(req_tdata[ptr_pkg::CELL_W +: ptr_pkg::SAMPLE_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ptr_pkg::mode_type'(ptr_pkg::MODE_RESET);
      end else if (csr_valid) begin
         mode_ff <= ptr_pkg::mode_type'(csr_wdata);
      end
   end

   // record update
   always_ff @(posedge clock) begin
      logic [64:0] as;
      case (dp_cmd.op)
         ptr_pkg::OP_LOAD: begin
            {mark_ff, cnt_ff, mean_ff, acc_ff} <= ram_rdata;
         end
         ptr_pkg::OP_SIMPLE: begin
            cnt_ff <= n_new;
            case (mode_ff)
               ptr_pkg::MODE_MIN: begin
                  if (cnt_ff == '0 || s64 < acc_ff) acc_ff <= s64;
                  mark_ff <= mark_ff | cnt_lost;
               end
               ptr_pkg::MODE_MAX: begin
                  if (cnt_ff == '0 || s64 > acc_ff) acc_ff <= s64;
                  mark_ff <= mark_ff | cnt_lost;
               end
               ptr_pkg::MODE_CNT: begin
                  as = add_sat(acc_ff, ONE_Q);
                  acc_ff  <= signed'(as[63:0]);
                  mark_ff <= mark_ff | as[64] | cnt_lost;
               end
               default: begin
                  as = add_sat(acc_ff, s64);
                  acc_ff  <= signed'(as[63:0]);
                  mark_ff <= mark_ff | as[64] | cnt_lost;
               end
            endcase
         end
         ptr_pkg::OP_PROD_END: begin
            cnt_ff  <= n_new;
            acc_ff  <= mulq;
            mark_ff <= mark_ff | mulsat | cnt_lost;
         end
         ptr_pkg::OP_MEAN: begin
            mean_ff <= mn64[ptr_pkg::MEAN_W-1:0];
         end
         ptr_pkg::OP_WEL_END: begin
            as = add_sat(acc_ff, mulq);
            cnt_ff  <= n_new;
            acc_ff  <= signed'(as[63:0]);
            mark_ff <= mark_ff | as[64] | mulsat | cnt_lost;
         end
         default: begin
         end
      endcase
   end

   assign ram_we    = (dp_cmd.op == ptr_pkg::OP_WRITE) || (dp_cmd.op == ptr_pkg::OP_CLEAR);
   assign ram_wdata = (dp_cmd.op == ptr_pkg::OP_CLEAR) ?
                      {1'b0, {ptr_pkg::CNT_W{1'b0}}, {ptr_pkg::MEAN_W{1'b0}}, clear_acc} :
                      {mark_ff, cnt_ff, mean_ff, acc_ff};

   ptr_ram #(
      .WIDTH (ptr_pkg::REC_W),
      .DEPTH (ptr_pkg::CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ptr_pkg::ADDR_W'(cell_ff)),
      .wdata (ram_wdata),
      .raddr (ptr_pkg::ADDR_W'(req_tdata[ptr_pkg::CELL_W-1:0])),
      .rdata (ram_rdata)
   );

   // result
   always_ff @(posedge clock) begin
      if (dp_cmd.op == ptr_pkg::OP_RES_PLAIN) begin
         case (mode_ff)
            ptr_pkg::MODE_MIN, ptr_pkg::MODE_MAX, ptr_pkg::MODE_MEAN: begin
               res_ok_ff  <= (cnt_ff != '0);
               res_val_ff <= (cnt_ff != '0) ? acc_ff : 64'sd0;
            end
            ptr_pkg::MODE_VAR, ptr_pkg::MODE_SD: begin
               res_ok_ff  <= (cnt_ff > 16'd1);
               res_val_ff <= (cnt_ff > 16'd1) ? acc_ff : 64'sd0;
            end
            default: begin
               res_ok_ff  <= 1'b1;
               res_val_ff <= acc_ff;
            end
         endcase
      end else if (dp_cmd.op == ptr_pkg::OP_RES_DIV) begin
         res_ok_ff  <= 1'b1;
         res_val_ff <= q64;
      end else if (dp_cmd.res_sqrt) begin
         res_ok_ff  <= 1'b1;
         res_val_ff <= signed'(root_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         rsp_cell_ff  <= cell_ff;
         rsp_value_ff <= res_val_ff;
         rsp_ok_ff    <= res_ok_ff;
         rsp_sat_ff   <= mark_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_value_ff, rsp_cell_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_ok_ff};

   assign dp_sts.cmd          = cmd_ff;
   assign dp_sts.mode         = mode_ff;
   assign dp_sts.cell_ok      = 32'(cell_ff) < ptr_pkg::CELLS;
   assign dp_sts.sample_valid = svalid_ff;
   assign dp_sts.cnt_zero     = (cnt_ff == '0);
   assign dp_sts.cnt_le1      = (cnt_ff <= 16'd1);
   assign dp_sts.unit_busy    = mbusy_ff | dbusy_ff | sbusy_ff;
   assign dp_sts.rsp_busy     = rsp_valid_ff & ~rsp_tready;

endmodule

FILE: hw/rtl/ptr_ctrl.sv
module ptr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output ptr_pkg::dp_cmd_type  dp_cmd,
   input  ptr_pkg::dp_sts_type  dp_sts
);

   ptr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      dp_cmd.op       = ptr_pkg::OP_NONE;
      dp_cmd.res_sqrt = 1'b0;
      dp_cmd.emit     = 1'b0;
      case (state_ff)
         ptr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.op = ptr_pkg::OP_LATCH;
               state_in  = ptr_pkg::S_LOAD;
            end
         end
         ptr_pkg::S_LOAD: begin
            dp_cmd.op = ptr_pkg::OP_LOAD;
            state_in  = ptr_pkg::S_IDLE;
            if (dp_sts.cell_ok) begin
               case (dp_sts.cmd)
                  ptr_pkg::CMD_CLEAR: state_in = ptr_pkg::S_CLEAR;
                  ptr_pkg::CMD_ACCUM: begin
                     if (dp_sts.sample_valid) state_in = ptr_pkg::S_ACC;
                  end
                  ptr_pkg::CMD_FINAL: state_in = ptr_pkg::S_FIN;
                  default:            state_in = ptr_pkg::S_IDLE;
               endcase
            end
         end
         ptr_pkg::S_CLEAR: begin
            dp_cmd.op = ptr_pkg::OP_CLEAR;
            state_in  = ptr_pkg::S_IDLE;
         end
         ptr_pkg::S_ACC: begin
            case (dp_sts.mode)
               ptr_pkg::MODE_PROD: begin
                  dp_cmd.op = ptr_pkg::OP_MUL_P;
                  state_in  = ptr_pkg::S_MUL_PROD;
               end
               ptr_pkg::MODE_VAR, ptr_pkg::MODE_SD: begin
                  dp_cmd.op = ptr_pkg::OP_DIV_D;
                  state_in  = ptr_pkg::S_DIV_MEAN;
               end
               default: begin
                  dp_cmd.op = ptr_pkg::OP_SIMPLE;
                  state_in  = ptr_pkg::S_WRITE;
               end
            endcase
         end
         ptr_pkg::S_MUL_PROD: begin
            if (!dp_sts.unit_busy) begin
               dp_cmd.op = ptr_pkg::OP_PROD_END;
               state_in  = ptr_pkg::S_WRITE;
            end
         end
         ptr_pkg::S_DIV_MEAN: begin
            if (!dp_sts.unit_busy) begin
               dp_cmd.op = ptr_pkg::OP_MEAN;
               state_in  = ptr_pkg::S_MUL_DEV;
            end
         end
         ptr_pkg::S_MUL_DEV: begin
            if (!dp_sts.unit_busy) begin
               dp_cmd.op = ptr_pkg::OP_WEL_END;
               state_in  = ptr_pkg::S_WRITE;
            end
         end
         ptr_pkg::S_WRITE: begin
            dp_cmd.op = ptr_pkg::OP_WRITE;
            state_in  = ptr_pkg::S_IDLE;
         end
         ptr_pkg::S_FIN: begin
            dp_cmd.op = ptr_pkg::OP_RES_PLAIN;
            state_in  = ptr_pkg::S_EMIT;
            case (dp_sts.mode)
               ptr_pkg::MODE_MEAN: begin
                  if (!dp_sts.cnt_zero) begin
                     dp_cmd.op = ptr_pkg::OP_DIV_N;
                     state_in  = ptr_pkg::S_DIV_FIN;
                  end
               end
               ptr_pkg::MODE_VAR, ptr_pkg::MODE_SD: begin
                  if (!dp_sts.cnt_le1) begin
                     dp_cmd.op = ptr_pkg::OP_DIV_N1;
                     state_in  = ptr_pkg::S_DIV_FIN;
                  end
               end
               default: begin
               end
            endcase
         end
         ptr_pkg::S_DIV_FIN: begin
            if (!dp_sts.unit_busy) begin
               if (dp_sts.mode == ptr_pkg::MODE_SD) begin
                  dp_cmd.op = ptr_pkg::OP_SQRT;
                  state_in  = ptr_pkg::S_SQRT;
               end else begin
                  dp_cmd.op = ptr_pkg::OP_RES_DIV;
                  state_in  = ptr_pkg::S_EMIT;
               end
            end
         end
         ptr_pkg::S_SQRT: begin
            if (!dp_sts.unit_busy) begin
               dp_cmd.res_sqrt = 1'b1;
               state_in        = ptr_pkg::S_EMIT;
            end
         end
         ptr_pkg::S_EMIT: begin
            if (!dp_sts.rsp_busy) begin
               dp_cmd.emit = 1'b1;
               state_in    = ptr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptr_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: tb/sv/per_cell_temporal_reducer_checker.sv
`timescale 1ns / 100ps

module per_cell_temporal_reducer_checker
   import ptr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [MODE_W-1:0]     csr_wdata,
   output int                    errors,
   output int                    waiting
);

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [CNT_W-1:0]   CNT_TOP = '1;

   typedef struct {
      logic [CELL_W-1:0]         cell_idx;
      logic signed [VALUE_W-1:0] value;
      logic                      ok;
      logic                      sat;
   } reduced_type;

   logic signed [VALUE_W-1:0] acc_mem [CELLS];
   logic [MEAN_W-1:0]         mean_mem [CELLS];
   logic [CNT_W-1:0]          cnt_mem [CELLS];
   logic                      mark_mem [CELLS];
   mode_type                  cur_mode;
   reduced_type               due_q [$];

   assign waiting = due_q.size();

   function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                inout logic sat);
      logic [127:0] ma, mb, p;
      logic         neg;
      neg = a[63] ^ b[63];
      ma  = {64'd0, (a[63] ? -a : a)};
      mb  = {64'd0, (b[63] ? -b : b)};
      p   = (ma * mb) >> FRAC_BITS;
      if (neg) begin
         if (p > 128'h8000_0000_0000_0000) begin
            sat = 1'b1;
            return S64_MIN;
         end
         return -p[63:0];
      end
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
         sat = 1'b1;
         return S64_MAX;
      end
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                inout logic sat);
      logic signed [64:0] t;
      t = {a[63], a} + {b[63], b};
      if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
         sat = 1'b1;
         return S64_MAX;
      end
      if (t < -65'sh0_8000_0000_0000_0000) begin
         sat = 1'b1;
         return S64_MIN;
      end
      return t[63:0];
   endfunction

   function automatic logic signed [63:0] q_sqrt(input logic signed [63:0] v);
      logic [127:0] tgt, c;
      logic [63:0]  r;
      r = '0;
      if (v <= 0) return 0;
      tgt = {64'd0, v} << FRAC_BITS;
      for (int b = 63; b >= 0; b--) begin
         c = {64'd0, r | (64'd1 << b)};
         if (c * c <= tgt) r = c[63:0];
      end
      return r;
   endfunction

   task automatic apply_word(input cmd_type cmd, input logic [CELL_W-1:0] c,
                             input logic signed [31:0] smp, input logic sv);
      logic signed [63:0] acc, s, m, d, mn, val, pm;
      logic [CNT_W-1:0]   old, n;
      logic               sat, ok;
      reduced_type        r;
      sat = 1'b0;
      ok  = 1'b0;
      val = 0;
      acc = acc_mem[c];
      s   = smp;
      case (cmd)
         CMD_CLEAR: begin
            acc_mem[c]  = (cur_mode == MODE_PROD) ? (64'sd1 <<< FRAC_BITS) : 64'sd0;
            mean_mem[c] = '0;
            cnt_mem[c]  = '0;
            mark_mem[c] = 1'b0;
         end
         CMD_ACCUM: begin
            if (sv) begin
               old = cnt_mem[c];
               n   = old;
               if (n != CNT_TOP) n++;
               else if (cur_mode inside {MODE_MEAN, MODE_VAR, MODE_SD}) sat = 1'b1;
               cnt_mem[c] = n;
               case (cur_mode)
                  MODE_MIN:  if (old == 0 || s < acc) acc = s;
                  MODE_MAX:  if (old == 0 || s > acc) acc = s;
                  MODE_MEAN, MODE_SUM: acc = q_add(acc, s, sat);
                  MODE_CNT:  acc = q_add(acc, 64'sd1 <<< FRAC_BITS, sat);
                  MODE_PROD: acc = q_mul(acc, s, sat);
                  default: begin
                     m  = {{16{mean_mem[c][MEAN_W-1]}}, mean_mem[c]};
                     d  = s - m;
                     mn = m + d / $signed({48'd0, n});
                     pm = q_mul(d, s - mn, sat);
                     acc = q_add(acc, pm, sat);
                     mean_mem[c] = mn[MEAN_W-1:0];
                  end
               endcase
               acc_mem[c] = acc;
               if (sat) mark_mem[c] = 1'b1;
            end
         end
         CMD_FINAL: begin
            n = cnt_mem[c];
            case (cur_mode)
               MODE_MIN, MODE_MAX: begin
                  ok  = n > 0;
                  val = acc;
               end
               MODE_MEAN: begin
                  ok = n > 0;
                  if (ok) val = acc / $signed({48'd0, n});
               end
               MODE_VAR, MODE_SD: begin
                  ok = n > 1;
                  if (ok) begin
                     val = acc / $signed({48'd0, n - 16'd1});
                     if (cur_mode == MODE_SD) val = q_sqrt(val);
                  end
               end
               default: begin
                  ok  = 1'b1;
                  val = acc;
               end
            endcase
            r.cell_idx = c;
            r.value    = ok ? val : 64'sd0;
            r.ok       = ok;
            r.sat      = mark_mem[c];
            due_q = {due_q, r};
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      reduced_type e;
      if (reset) begin
         cur_mode = mode_type'(MODE_RESET);
         due_q.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) cur_mode = mode_type'(csr_wdata);
         if (req_tvalid && req_tready)
            apply_word(cmd_type'(req_tuser[1:0]), req_tdata[11:0], req_tdata[43:12],
                       req_tuser[2]);
         if (rsp_tvalid && rsp_tready) begin
            if (due_q.size() == 0) begin
               $display("%0t: unexpected result word cell=%0d value=%h", $time,
                        rsp_tdata[11:0], rsp_tdata[75:12]);
               errors <= errors + 1;
            end else begin
               e = due_q.pop_front();
               if (rsp_tdata[11:0] !== e.cell_idx || rsp_tdata[75:12] !== e.value ||
                   rsp_tuser[0] !== e.ok || rsp_tuser[1] !== e.sat) begin
                  $display("%0t: mismatch expected cell=%0d value=%h ok=%b sat=%b",
                           $time, e.cell_idx, e.value, e.ok, e.sat);
                  $display("%0t:          actual   cell=%0d value=%h ok=%b sat=%b",
                           $time, rsp_tdata[11:0], rsp_tdata[75:12], rsp_tuser[0],
                           rsp_tuser[1]);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/sv/per_cell_temporal_reducer_test.sv
`timescale 1ns / 100ps

module per_cell_temporal_reducer_test;
   import ptr_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 50000;
   localparam int SETTLE = 300;
   localparam int RAND_ITEMS = 1600;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid, csr_ready;
   logic [MODE_W-1:0]     csr_wdata;
   int                    errors, waiting;
   int                    req_idle, rsp_stall, quiet, rand_count;
   bit                    live [CELLS];
   logic [CELL_W-1:0]     live_q [$];

   per_cell_temporal_reducer u_dut (.*);

   per_cell_temporal_reducer_checker u_chk (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push(input logic [CMD_W-1:0] op, input logic [CELL_W-1:0] c,
                       input logic [31:0] smp, input logic sv);
      logic hs;
      if ($urandom_range(99) < req_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, smp, c};
      req_tuser  <= {sv, op};
      do begin
         @(negedge clock);
         hs = req_tready;
         @(posedge clock);
      end while (!hs);
      if (op == CMD_CLEAR && !live[c]) begin
         live[c] = 1'b1;
         live_q = {live_q, c};
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(input mode_type m);
      logic hs;
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do begin
         @(negedge clock);
         hs = csr_ready;
         @(posedge clock);
      end while (!hs);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] any_sample;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 1 << 20) - (1 << 19);
         2: case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h0001_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return $urandom_range(0, 1 << 18) + 32'h0000_8000;
      endcase
   endfunction

   initial begin
      logic [CELL_W-1:0] c;
      mode_type          m;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      rsp_tready <= 1'b0;
      quiet      <= 0;
      req_idle   = 0;
      rsp_stall  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cells, then extremes in default sum mode
      push(CMD_CLEAR, 12'd0, 32'h0, 1'b0);
      push(CMD_FINAL, 12'd0, 32'h0, 1'b0);
      push(CMD_ACCUM, 12'd0, 32'h7FFF_FFFF, 1'b1);
      push(CMD_ACCUM, 12'd0, 32'h8000_0000, 1'b1);
      push(CMD_ACCUM, 12'd0, 32'h1234_5678, 1'b0);
      push(CMD_SPARE, 12'd0, 32'hFFFF_FFFF, 1'b1);
      push(CMD_FINAL, 12'd0, 32'h0, 1'b0);
      push(CMD_CLEAR, 12'd4095, 32'h0, 1'b0);
      push(CMD_ACCUM, 12'd4095, 32'hFFFF_FFFF, 1'b1);
      push(CMD_FINAL, 12'd4095, 32'h0, 1'b0);
      for (int k = 0; k < 8; k++) begin
         set_mode(mode_type'(k));
         push(CMD_CLEAR, 12'd1, 32'h0, 1'b0);
         push(CMD_FINAL, 12'd1, 32'h0, 1'b0);
         push(CMD_ACCUM, 12'd1, 32'hFFFE_0000, 1'b1);
         push(CMD_FINAL, 12'd1, 32'h0, 1'b0);
         push(CMD_ACCUM, 12'd1, 32'h0003_8000, 1'b1);
         push(CMD_FINAL, 12'd1, 32'h0, 1'b0);
      end
      // product saturation both ways, then sum and count on saturated cells
      set_mode(MODE_PROD);
      push(CMD_CLEAR, 12'd2, 32'h0, 1'b0);
      push(CMD_CLEAR, 12'd3, 32'h0, 1'b0);
      repeat (5) push(CMD_ACCUM, 12'd2, 32'h7FFF_FFFF, 1'b1);
      repeat (5) push(CMD_ACCUM, 12'd3, 32'h8000_0000, 1'b1);
      push(CMD_FINAL, 12'd2, 32'h0, 1'b0);
      push(CMD_FINAL, 12'd3, 32'h0, 1'b0);
      set_mode(MODE_SUM);
      push(CMD_ACCUM, 12'd2, 32'h7FFF_FFFF, 1'b1);
      push(CMD_ACCUM, 12'd3, 32'h8000_0000, 1'b1);
      push(CMD_FINAL, 12'd3, 32'h0, 1'b0);
      set_mode(MODE_CNT);
      push(CMD_ACCUM, 12'd2, 32'h0, 1'b1);
      push(CMD_FINAL, 12'd2, 32'h0, 1'b0);
      // negative accumulator read as sd
      set_mode(MODE_SUM);
      push(CMD_CLEAR, 12'd4, 32'h0, 1'b0);
      repeat (3) push(CMD_ACCUM, 12'd4, 32'hFFF0_0000, 1'b1);
      set_mode(MODE_SD);
      push(CMD_FINAL, 12'd4, 32'h0, 1'b0);
      // longer mean run on one cell
      set_mode(MODE_MEAN);
      push(CMD_CLEAR, 12'd5, 32'h0, 1'b0);
      repeat (24) push(CMD_ACCUM, 12'd5, $urandom_range(0, 255), 1'b1);
      push(CMD_FINAL, 12'd5, 32'h0, 1'b0);

      rand_count = 0;
      for (int ph = 0; rand_count < RAND_ITEMS; ph++) begin
         m = (ph < 8) ? mode_type'(ph) : mode_type'($urandom_range(7));
         set_mode(m);
         case (ph % 4)
            0: begin req_idle = 0;  rsp_stall = 0;  end
            1: begin req_idle = 87; rsp_stall = 0;  end
            2: begin req_idle = 0;  rsp_stall = 87; end
            default: begin req_idle = 15; rsp_stall = 15; end
         endcase
         for (int k = 0; k < 160; ) begin
            if ($urandom_range(9) == 0) begin
               push(CMD_SPARE, CELL_W'($urandom), $urandom, 1'($urandom_range(1)));
               continue;
            end
            if (live_q.size() > 8 && $urandom_range(9) < 3) begin
               c = live_q[$urandom_range(live_q.size() - 1)];
            end else begin
               c = CELL_W'($urandom);
               push(CMD_CLEAR, c, $urandom, 1'($urandom_range(1)));
               k++;
            end
            repeat ($urandom_range(0, 6)) begin
               push(CMD_ACCUM, c, any_sample(), $urandom_range(9) != 0);
               k++;
            end
            push(CMD_FINAL, c, $urandom, 1'($urandom_range(1)));
            k++;
         end
         rand_count += 160;
      end

      drain();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
